// ===== sv/tcld_pkg.sv =====
package tcld_pkg;

  localparam int LINE_CAP    = 64;
  localparam int STORE_DEPTH = LINE_CAP - 1;
  localparam int LEN_W       = $clog2(LINE_CAP);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int MAX_TOK = 6;
  localparam int TOK_W   = 3;
  localparam int NUM_W   = 10;
  localparam int POS_W   = 3;

  localparam logic [NUM_W-1:0] NUM_SAT   = NUM_W'(1000);
  localparam logic [NUM_W-1:0] DUTY_MAX  = NUM_W'(999);
  localparam logic [NUM_W-1:0] LED_MAX   = NUM_W'(5);
  localparam logic [NUM_W-1:0] MOTOR_MIN = NUM_W'(1);
  localparam logic [NUM_W-1:0] MOTOR_MAX = NUM_W'(4);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [4:0] {
    K_INFO          = 5'd0,
    K_MANUAL        = 5'd1,
    K_AUTO          = 5'd2,
    K_LED           = 5'd3,
    K_STOP          = 5'd4,
    K_IDLE          = 5'd5,
    K_ALL           = 5'd6,
    K_SINGLE        = 5'd7,
    E_MODE_MISSING  = 5'd8,
    E_MODE_BAD      = 5'd9,
    E_LED_MISSING   = 5'd10,
    E_LED_QUERY     = 5'd11,
    E_LED_RANGE     = 5'd12,
    E_MOTOR_MISSING = 5'd13,
    E_ALL_MISSING   = 5'd14,
    E_ALL_RANGE     = 5'd15,
    E_MOTOR_RANGE   = 5'd16,
    E_DUTY_MISSING  = 5'd17,
    E_DUTY_RANGE    = 5'd18,
    E_UNKNOWN       = 5'd19
  } kind_t;

  localparam int NUM_KW  = 10;
  localparam int KW_INFO   = 0;
  localparam int KW_MODE   = 1;
  localparam int KW_LED    = 2;
  localparam int KW_MOTOR  = 3;
  localparam int KW_MANUAL = 4;
  localparam int KW_AUTO   = 5;
  localparam int KW_QUERY  = 6;
  localparam int KW_STOP   = 7;
  localparam int KW_IDLE   = 8;
  localparam int KW_ALL    = 9;

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"i", "n", "f", "o", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "o", "d", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "o", "t", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"m", "a", "n", "u", "a", "l", 8'h00, 8'h00},
    '{"a", "u", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"?", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "t", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "d", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [POS_W-1:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd4, 3'd3, 3'd5, 3'd6, 3'd4, 3'd1, 3'd4, 3'd4, 3'd3
  };

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } num_t;

  typedef struct packed {
    logic [TOK_W-1:0]        count;
    logic [NUM_KW-1:0]       kw0;
    logic [NUM_KW-1:0]       kw1;
    num_t [MAX_TOK-1:1]      nums;
  } scan_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // value lies in lo..hi; a minus sign is harmless only on zero
  function automatic logic num_in(input num_t n, input logic [NUM_W-1:0] lo,
                                  input logic [NUM_W-1:0] hi);
    return (!n.neg || n.mag == '0) && n.mag >= lo && n.mag <= hi;
  endfunction

endpackage

// ===== sv/tcld_rx_if.sv =====
interface tcld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/tcld_res_if.sv =====
interface tcld_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] result_kind;
  logic [2:0] led_mode;
  logic [1:0] motor_index;
  logic [9:0] duty_first;
  logic [9:0] duty_second;
  logic [9:0] duty_third;
  logic [9:0] duty_fourth;

  modport source (output valid, output result_kind, output led_mode, output motor_index,
                  output duty_first, output duty_second, output duty_third,
                  output duty_fourth, input ready);
  modport sink (input valid, input result_kind, input led_mode, input motor_index,
                input duty_first, input duty_second, input duty_third,
                input duty_fourth, output ready);
endinterface

// ===== sv/tcld_line_ram.sv =====
module tcld_line_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tcld_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [tcld_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                 rdata
);
  import tcld_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/tcld_token_scan.sv =====
module tcld_token_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            ch_valid,
  input  logic [7:0]      ch,
  input  logic            finish,
  output tcld_pkg::scan_t res
);
  import tcld_pkg::*;

  typedef enum logic [1:0] {P_WS, P_DIG, P_END} phase_t;

  logic              in_tok;
  logic [TOK_W-1:0]  cnt;
  logic [POS_W-1:0]  pos;
  logic [NUM_KW-1:0] match;
  phase_t            phase;
  logic              neg;
  logic [NUM_W-1:0]  mag;
  logic [NUM_KW-1:0] kw0;
  logic [NUM_KW-1:0] kw1;
  num_t [MAX_TOK-1:1] nums;

  logic [7:0]        c;
  logic              delim;
  logic              start_tok;
  logic              step;
  logic              commit;
  logic [POS_W-1:0]  cur_pos;
  logic [NUM_KW-1:0] cur_match;
  phase_t            cur_phase;
  logic              cur_neg;
  logic [NUM_W-1:0]  cur_mag;
  logic [POS_W-1:0]  pos_next;
  logic [NUM_KW-1:0] match_next;
  phase_t            phase_next;
  logic              neg_next;
  logic [NUM_W-1:0]  mag_next;
  logic              is_digit;
  logic [13:0]       acc;
  logic [NUM_KW-1:0] matched;

  assign c         = fold(ch);
  assign delim     = is_delim(c);
  assign start_tok = ch_valid && !delim && !in_tok && cnt < TOK_W'(MAX_TOK);
  assign step      = ch_valid && !delim && (in_tok || start_tok);
  assign commit    = in_tok && ((ch_valid && delim) || finish);

  assign cur_pos   = start_tok ? '0 : pos;
  assign cur_match = start_tok ? '1 : match;
  assign cur_phase = start_tok ? P_WS : phase;
  assign cur_neg   = start_tok ? 1'b0 : neg;
  assign cur_mag   = start_tok ? '0 : mag;

  assign pos_next = (cur_pos == '1) ? cur_pos : cur_pos + 1'b1;
  assign is_digit = c >= "0" && c <= "9";
  assign acc      = 14'(cur_mag) * 14'd10 + 14'(c - "0");

  always_comb begin
    for (int w = 0; w < NUM_KW; w++) begin
      match_next[w] = cur_match[w] && cur_pos < KW_LEN[w] && c == KW_TEXT[w][cur_pos];
      matched[w]    = match[w] && pos == KW_LEN[w];
    end
  end

  always_comb begin
    phase_next = cur_phase;
    neg_next   = cur_neg;
    mag_next   = cur_mag;
    case (cur_phase)
      P_WS: begin
        if (is_space(c)) begin
          phase_next = P_WS;
        end else if (c == "+" || c == "-") begin
          neg_next   = c == "-";
          phase_next = P_DIG;
        end else if (is_digit) begin
          mag_next   = acc > 14'(NUM_SAT) ? NUM_SAT : acc[NUM_W-1:0];
          phase_next = P_DIG;
        end else begin
          phase_next = P_END;
        end
      end
      P_DIG: begin
        if (is_digit) begin
          mag_next = acc > 14'(NUM_SAT) ? NUM_SAT : acc[NUM_W-1:0];
        end else begin
          phase_next = P_END;
        end
      end
      P_END: phase_next = P_END;
      default: phase_next = P_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      in_tok <= 1'b0;
      cnt    <= '0;
    end else begin
      if (step) begin
        in_tok <= 1'b1;
        pos    <= pos_next;
        match  <= match_next;
        phase  <= phase_next;
        neg    <= neg_next;
        mag    <= mag_next;
      end
      if (commit) begin
        in_tok <= 1'b0;
        cnt    <= cnt + 1'b1;
        if (cnt == '0) begin
          kw0 <= matched;
        end
        if (cnt == TOK_W'(1)) begin
          kw1 <= matched;
        end
        if (cnt != '0) begin
          nums[cnt] <= '{neg: neg, mag: mag};
        end
      end
    end
  end

  assign res.count = cnt;
  assign res.kw0   = kw0;
  assign res.kw1   = kw1;
  assign res.nums  = nums;
endmodule

// ===== sv/text_command_line_decoder.sv =====
// text command line decoder
// rx channel: one received byte per request. bytes are kept in a line store
// of LINE_CAP-1 entries; later bytes of an overlong line are dropped.
// a newline byte (0x0A) ends the line and starts the decode; a newline on an
// empty line gives nothing.
// res channel: at most one command or error request per line, carrying the
// kind code, led pattern, motor index and up to four duties.
// the line store has one read port, so on a newline the walk reads one stored
// byte per cycle, then a drain state passes the last byte to the scanner, a
// flush state closes the last token and an emit state loads the result register.
// rx is held off from the start of the walk until the emit state is done.
// when res is stalled the finished result waits in its register; bytes of
// the next line are still taken, but the next newline decode holds until
// the register is free.
// reset (synchronous, rst high) empties the line and the result register;
// the store itself needs no clearing.
module text_command_line_decoder (
  input logic        clk,
  input logic        rst,
  tcld_rx_if.sink    rx,
  tcld_res_if.source res
);
  import tcld_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_FLUSH, S_EMIT} state_t;

  state_t            state;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_pend;
  logic              stopped;

  logic              out_valid;
  kind_t             out_kind;
  logic [2:0]        out_led;
  logic [1:0]        out_motor;
  logic [NUM_W-1:0]  out_d1;
  logic [NUM_W-1:0]  out_d2;
  logic [NUM_W-1:0]  out_d3;
  logic [NUM_W-1:0]  out_d4;

  logic              accept;
  logic              is_nl;
  logic              wr_en;
  logic [7:0]        rdata;
  logic              ch_valid;
  logic              scan_clear;
  logic              load;
  scan_t             scan;

  kind_t             d_kind;
  logic [2:0]        d_led;
  logic [1:0]        d_motor;
  logic [NUM_W-1:0]  d_d1;
  logic [NUM_W-1:0]  d_d2;
  logic [NUM_W-1:0]  d_d3;
  logic [NUM_W-1:0]  d_d4;

  assign rx.ready   = state == S_IDLE;
  assign accept     = rx.valid && rx.ready;
  assign is_nl      = rx.rx_byte == CH_NEWLINE;
  assign wr_en      = accept && !is_nl && len < LEN_W'(STORE_DEPTH);
  assign ch_valid   = rd_pend && !stopped && rdata != CH_NUL;
  assign scan_clear = accept && is_nl;
  assign load       = state == S_EMIT && scan.count != '0 && (!out_valid || res.ready);

  tcld_line_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len[ADDR_W-1:0]),
    .wdata (rx.rx_byte),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  tcld_token_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .clear    (scan_clear),
    .ch_valid (ch_valid),
    .ch       (rdata),
    .finish   (state == S_FLUSH),
    .res      (scan)
  );

  always_comb begin
    d_kind  = E_UNKNOWN;
    d_led   = '0;
    d_motor = '0;
    d_d1    = '0;
    d_d2    = '0;
    d_d3    = '0;
    d_d4    = '0;
    if (scan.kw0[KW_INFO]) begin
      d_kind = K_INFO;
    end else if (scan.kw0[KW_MODE]) begin
      if (scan.count < TOK_W'(2)) d_kind = E_MODE_MISSING;
      else if (scan.kw1[KW_MANUAL]) d_kind = K_MANUAL;
      else if (scan.kw1[KW_AUTO]) d_kind = K_AUTO;
      else d_kind = E_MODE_BAD;
    end else if (scan.kw0[KW_LED]) begin
      if (scan.count < TOK_W'(2)) begin
        d_kind = E_LED_MISSING;
      end else if (scan.kw1[KW_QUERY]) begin
        d_kind = E_LED_QUERY;
      end else if (num_in(scan.nums[1], '0, LED_MAX)) begin
        d_kind = K_LED;
        d_led  = scan.nums[1].mag[2:0];
      end else begin
        d_kind = E_LED_RANGE;
      end
    end else if (scan.kw0[KW_MOTOR]) begin
      if (scan.count < TOK_W'(2)) begin
        d_kind = E_MOTOR_MISSING;
      end else if (scan.kw1[KW_STOP]) begin
        d_kind = K_STOP;
      end else if (scan.kw1[KW_IDLE]) begin
        d_kind = K_IDLE;
      end else if (scan.kw1[KW_ALL]) begin
        if (scan.count < TOK_W'(MAX_TOK)) begin
          d_kind = E_ALL_MISSING;
        end else if (num_in(scan.nums[2], '0, DUTY_MAX) && num_in(scan.nums[3], '0, DUTY_MAX)
                     && num_in(scan.nums[4], '0, DUTY_MAX)
                     && num_in(scan.nums[5], '0, DUTY_MAX)) begin
          d_kind = K_ALL;
          d_d1   = scan.nums[2].mag;
          d_d2   = scan.nums[3].mag;
          d_d3   = scan.nums[4].mag;
          d_d4   = scan.nums[5].mag;
        end else begin
          d_kind = E_ALL_RANGE;
        end
      end else if (!num_in(scan.nums[1], MOTOR_MIN, MOTOR_MAX)) begin
        d_kind = E_MOTOR_RANGE;
      end else if (scan.count < TOK_W'(3)) begin
        d_kind = E_DUTY_MISSING;
      end else if (num_in(scan.nums[2], '0, DUTY_MAX)) begin
        d_kind  = K_SINGLE;
        d_motor = 2'(scan.nums[1].mag - 1'b1);
        d_d1    = scan.nums[2].mag;
      end else begin
        d_kind = E_DUTY_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (accept) begin
            if (is_nl) begin
              if (len != '0) begin
                rd_addr <= '0;
                stopped <= 1'b0;
                state   <= S_WALK;
              end
            end else if (wr_en) begin
              len <= len + 1'b1;
            end
          end
        end
        S_WALK: begin
          rd_pend <= 1'b1;
          if (rd_pend && rdata == CH_NUL) begin
            stopped <= 1'b1;
          end
          rd_addr <= rd_addr + 1'b1;
          if (LEN_W'(rd_addr) + 1'b1 == len) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last stored byte is seen by the scanner this cycle
          rd_pend <= 1'b0;
          state   <= S_FLUSH;
        end
        S_FLUSH: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (scan.count == '0) begin
            len   <= '0;
            state <= S_IDLE;
          end else if (load) begin
            out_valid <= 1'b1;
            out_kind  <= d_kind;
            out_led   <= d_led;
            out_motor <= d_motor;
            out_d1    <= d_d1;
            out_d2    <= d_d2;
            out_d3    <= d_d3;
            out_d4    <= d_d4;
            len       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.led_mode    = out_led;
  assign res.motor_index = out_motor;
  assign res.duty_first  = out_d1;
  assign res.duty_second = out_d2;
  assign res.duty_third  = out_d3;
  assign res.duty_fourth = out_d4;
endmodule
